// ===== hdl/nwcl_pkg.sv =====
// Shared types and constants for the neighbor weighted color label block.
// Used by nwcl_cell and neighbor_weighted_color_label; no dependencies.
package nwcl_pkg;

    localparam int LABEL_W   = 4;
    localparam int COLOR_W   = 8;
    localparam int NBR_COUNT = 8;
    localparam int NBR_W     = NBR_COUNT * LABEL_W;
    localparam int DIST_W    = 18;
    localparam int CNT_W     = 4;
    localparam int WEIGHT_W  = 16;
    localparam int SCORE_W   = 20;
    localparam int MEANS_W   = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MEANS_IN_USE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ADJACENCY_WEIGHT = 1'b1;

    localparam logic [MEANS_W-1:0]  MEANS_IN_USE_RESET     = 5'd13;
    localparam logic [WEIGHT_W-1:0] ADJACENCY_WEIGHT_RESET = 16'd4000;

    typedef enum logic
    {
        FUNC_LABEL = 1'b0,
        FUNC_LOAD  = 1'b1
    } func_t;

    typedef struct packed
    {
        func_t                      func;
        logic [LABEL_W-1:0]         mean_index;
        logic [COLOR_W-1:0]         red;
        logic [COLOR_W-1:0]         green;
        logic [COLOR_W-1:0]         blue;
        logic [LABEL_W-1:0]         current_label;
        logic [NBR_W-1:0]           neighbour_labels;
        logic [LABEL_W-1:0]         best_label;
        logic signed [SCORE_W-1:0]  best_score;
    } beat_t;

endpackage

// ===== hdl/neighbor_weighted_color_label.sv =====
// Top level of the neighbor weighted color label block: config registers,
// cell chain and output register. Depends on nwcl_pkg and nwcl_cell.
//
// Usage: each beat on the pixel channel is either a mean load (func = 1),
// which writes one RGB mean into its slot and yields no result, or a pixel
// (func = 0), which yields one result beat: the label of lowest score
// (squared color distance minus adjacency_weight per agreeing neighbour,
// lower label on ties), that score and a changed flag.
// The beat walks a chain of MAX_MEANS cells, two register stages each; the
// cell for slot s holds mean s and folds its score into the running best.
// The last cell feeds the output register. Throughput: one beat per cycle,
// loads and pixels mixed, while the result register is not stalled.
// Loads travel the chain in order, so a pixel sees every load taken before it.
// Reset empties the chain and the result register and loads the register
// defaults; mean slots stay undefined until loaded.
// A stalled result register holds its beat and freezes the whole chain;
// pixel_ready is low only while a result waits and result_ready is low.
// Config writes (cfg_we) take effect next cycle; write them while idle.
module neighbor_weighted_color_label #(
    parameter int MAX_MEANS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [nwcl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nwcl_pkg::WEIGHT_W-1:0]   cfg_data,
    input  logic                            pixel_valid,
    output logic                            pixel_ready,
    input  logic                            func,
    input  logic [nwcl_pkg::LABEL_W-1:0]    mean_index,
    input  logic [nwcl_pkg::COLOR_W-1:0]    red,
    input  logic [nwcl_pkg::COLOR_W-1:0]    green,
    input  logic [nwcl_pkg::COLOR_W-1:0]    blue,
    input  logic [nwcl_pkg::LABEL_W-1:0]    current_label,
    input  logic [nwcl_pkg::NBR_W-1:0]      neighbour_labels,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [nwcl_pkg::LABEL_W-1:0]    chosen_label,
    output logic                            label_changed,
    output logic signed [nwcl_pkg::SCORE_W-1:0] best_score
);
    import nwcl_pkg::*;

    logic [MEANS_W-1:0]  means_in_use_reg;
    logic [WEIGHT_W-1:0] adjacency_weight_reg;
    logic [MEANS_W-1:0]  k_eff;
    logic                advance;
    logic                chain_valid [0:MAX_MEANS];
    beat_t               chain_beat  [0:MAX_MEANS];
    logic                result_valid_reg;
    logic                result_valid_next;
    logic [LABEL_W-1:0]  chosen_label_reg;
    logic                label_changed_reg;
    logic signed [SCORE_W-1:0] best_score_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            means_in_use_reg     <= MEANS_IN_USE_RESET;
            adjacency_weight_reg <= ADJACENCY_WEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MEANS_IN_USE:     means_in_use_reg     <= cfg_data[MEANS_W-1:0];
                REG_ADJACENCY_WEIGHT: adjacency_weight_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        if (means_in_use_reg == '0)
        begin
            k_eff = MEANS_W'(1);
        end
        else if (means_in_use_reg > MEANS_W'(MAX_MEANS))
        begin
            k_eff = MEANS_W'(MAX_MEANS);
        end
        else
        begin
            k_eff = means_in_use_reg;
        end
    end

    assign advance     = !result_valid_reg || result_ready;
    assign pixel_ready = advance;

    always_comb
    begin
        chain_valid[0]                 = pixel_valid;
        chain_beat[0].func             = func_t'(func);
        chain_beat[0].mean_index       = mean_index;
        chain_beat[0].red              = red;
        chain_beat[0].green            = green;
        chain_beat[0].blue             = blue;
        chain_beat[0].current_label    = current_label;
        chain_beat[0].neighbour_labels = neighbour_labels;
        chain_beat[0].best_label       = '0;
        chain_beat[0].best_score       = '0;
    end

    for (genvar s = 0; s < MAX_MEANS; s++)
    begin : g_cell
        nwcl_cell #(
            .CELL_INDEX (s)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .k_eff      (k_eff),
            .weight     (adjacency_weight_reg),
            .prev_valid (chain_valid[s]),
            .prev_beat  (chain_beat[s]),
            .next_valid (chain_valid[s+1]),
            .next_beat  (chain_beat[s+1])
        );
    end

    // drop load beats at the end of the chain
    assign result_valid_next = chain_valid[MAX_MEANS]
                               && (chain_beat[MAX_MEANS].func == FUNC_LABEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            chosen_label_reg  <= chain_beat[MAX_MEANS].best_label;
            label_changed_reg <= (chain_beat[MAX_MEANS].best_label
                                  != chain_beat[MAX_MEANS].current_label);
            best_score_reg    <= chain_beat[MAX_MEANS].best_score;
        end
    end

    assign result_valid  = result_valid_reg;
    assign chosen_label  = chosen_label_reg;
    assign label_changed = label_changed_reg;
    assign best_score    = best_score_reg;

endmodule

// ===== hdl/nwcl_cell.sv =====
// One cell of the label chain: holds one color mean and scores the passing pixel.
// Depends on nwcl_pkg.
module nwcl_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [nwcl_pkg::MEANS_W-1:0]  k_eff,
    input  logic [nwcl_pkg::WEIGHT_W-1:0] weight,
    input  logic                          prev_valid,
    input  nwcl_pkg::beat_t               prev_beat,
    output logic                          next_valid,
    output nwcl_pkg::beat_t               next_beat
);
    import nwcl_pkg::*;

    localparam logic [LABEL_W-1:0] CELL_LABEL = LABEL_W'(CELL_INDEX);

    logic [COLOR_W-1:0]  mean_red_reg;
    logic [COLOR_W-1:0]  mean_green_reg;
    logic [COLOR_W-1:0]  mean_blue_reg;
    logic                a_valid_reg;
    beat_t               a_beat_reg;
    logic [DIST_W-1:0]   a_dist_reg;
    logic [CNT_W-1:0]    a_cnt_reg;
    logic [DIST_W-1:0]   dist_next;
    logic [CNT_W-1:0]    cnt_next;
    logic                b_valid_reg;
    beat_t               b_beat_reg;
    beat_t               b_beat_next;
    logic [SCORE_W-1:0]  penalty;
    logic signed [SCORE_W-1:0] score;
    logic                cell_active;
    logic                take;
    logic                is_load_here;

    function automatic logic [2*COLOR_W-1:0] sqdiff(
        input logic [COLOR_W-1:0] a,
        input logic [COLOR_W-1:0] b
    );
        logic [COLOR_W-1:0] d;
        begin
            d = (a > b) ? (a - b) : (b - a);
            return d * d;
        end
    endfunction

    always_comb
    begin
        dist_next = DIST_W'(sqdiff(mean_red_reg, prev_beat.red))
                  + DIST_W'(sqdiff(mean_green_reg, prev_beat.green))
                  + DIST_W'(sqdiff(mean_blue_reg, prev_beat.blue));
        cnt_next = '0;
        for (int n = 0; n < NBR_COUNT; n++)
        begin
            if (prev_beat.neighbour_labels[n*LABEL_W +: LABEL_W] == CELL_LABEL)
            begin
                cnt_next = cnt_next + CNT_W'(1);
            end
        end
    end

    assign is_load_here = prev_valid && (prev_beat.func == FUNC_LOAD)
                          && (prev_beat.mean_index == CELL_LABEL);

    // hold the mean; replace it when a load beat for this slot passes
    always_ff @(posedge clk)
    begin
        if (advance && is_load_here)
        begin
            mean_red_reg   <= prev_beat.red;
            mean_green_reg <= prev_beat.green;
            mean_blue_reg  <= prev_beat.blue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= prev_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_beat_reg <= prev_beat;
            a_dist_reg <= dist_next;
            a_cnt_reg  <= cnt_next;
            b_beat_reg <= b_beat_next;
        end
    end

    assign cell_active = ({1'b0, CELL_LABEL} < k_eff);
    assign penalty     = SCORE_W'(weight * a_cnt_reg);
    assign score       = $signed(SCORE_W'(a_dist_reg) - penalty);
    assign take        = (CELL_INDEX == 0)
                         || (cell_active && (score < a_beat_reg.best_score));

    always_comb
    begin
        b_beat_next = a_beat_reg;
        if (take)
        begin
            b_beat_next.best_label = CELL_LABEL;
            b_beat_next.best_score = score;
        end
    end

    assign next_valid = b_valid_reg;
    assign next_beat  = b_beat_reg;

endmodule

// ===== hdl/nwcl_checker.sv =====
// Port-level checks for neighbor_weighted_color_label, bound to the top level.
// Depends on nwcl_pkg.
module nwcl_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pixel_ready,
    input  logic                               result_valid,
    input  logic                               result_ready,
    input  logic [nwcl_pkg::LABEL_W-1:0]       chosen_label,
    input  logic                               label_changed,
    input  logic signed [nwcl_pkg::SCORE_W-1:0] best_score
);
    import nwcl_pkg::*;

    localparam logic signed [SCORE_W-1:0] SCORE_MIN = -20'sd524280;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 20'sd195075;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(chosen_label)
            && $stable(label_changed) && $stable(best_score))
        else $error("result beat changed while stalled");

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_ready == (!result_valid || result_ready))
        else $error("pixel_ready does not track the result register");

    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result valid right after reset");

    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (best_score >= SCORE_MIN) && (best_score <= SCORE_MAX))
        else $error("best_score out of range");

endmodule

bind neighbor_weighted_color_label nwcl_checker u_nwcl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pixel_ready   (pixel_ready),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .chosen_label  (chosen_label),
    .label_changed (label_changed),
    .best_score    (best_score)
);

// ===== bench/nwcl_label_check_pkg.sv =====
// Beat types and the label scoreboard for the neighbor weighted color label bench.
// Depends on nwcl_pkg for field widths, the func encoding and register indexes.
package nwcl_label_check_pkg;

    import nwcl_pkg::*;

    localparam int MEAN_SLOTS = 16;

    typedef struct packed
    {
        func_t                  func;
        logic [LABEL_W-1:0]     mean_index;
        logic [COLOR_W-1:0]     red;
        logic [COLOR_W-1:0]     green;
        logic [COLOR_W-1:0]     blue;
        logic [LABEL_W-1:0]     current_label;
        logic [NBR_W-1:0]       neighbour_labels;
    } pixel_beat_t;

    typedef struct packed
    {
        logic [LABEL_W-1:0]         label;
        logic                       changed;
        logic signed [SCORE_W-1:0]  score;
    } label_result_t;

    class label_scoreboard;

        logic [3*COLOR_W-1:0]  mean_slot [MEAN_SLOTS];
        logic [MEANS_W-1:0]    means_in_use = MEANS_IN_USE_RESET;
        logic [WEIGHT_W-1:0]   adjacency_weight = ADJACENCY_WEIGHT_RESET;
        label_result_t         pending_labels [$];
        int                    mismatches = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [WEIGHT_W-1:0] data);
            if (index == REG_MEANS_IN_USE)
                means_in_use = data[MEANS_W-1:0];
            else
                adjacency_weight = data;
        endfunction

        function int active_means();
            if (means_in_use == 0)
                return 1;
            if (means_in_use > MEAN_SLOTS)
                return MEAN_SLOTS;
            return int'(means_in_use);
        endfunction

        function int pending();
            return pending_labels.size();
        endfunction

        function void note_beat(pixel_beat_t b);
            int k;
            int d;
            int s;
            int lab;
            int dr;
            int dg;
            int db;
            int score;
            int best_score;
            int best;
            int tally [MEAN_SLOTS];
            label_result_t r;
            if (b.func == FUNC_LOAD)
            begin
                mean_slot[b.mean_index] = {b.red, b.green, b.blue};
                return;
            end
            k = active_means();
            for (s = 0; s < MEAN_SLOTS; s++)
                tally[s] = 0;
            for (d = 0; d < NBR_COUNT; d++)
            begin
                lab = int'(b.neighbour_labels[LABEL_W*d +: LABEL_W]);
                if (lab < k)
                    tally[lab]++;
            end
            best = 0;
            best_score = 0;
            for (s = 0; s < k; s++)
            begin
                dr = int'(mean_slot[s][23:16]) - int'(b.red);
                dg = int'(mean_slot[s][15:8]) - int'(b.green);
                db = int'(mean_slot[s][7:0]) - int'(b.blue);
                score = dr * dr + dg * dg + db * db - int'(adjacency_weight) * tally[s];
                if (s == 0 || score < best_score)
                begin
                    best_score = score;
                    best = s;
                end
            end
            r.label = LABEL_W'(best);
            r.changed = (r.label != b.current_label);
            r.score = SCORE_W'(best_score);
            pending_labels.push_back(r);
        endfunction

        function void check_label(logic [LABEL_W-1:0] label, logic changed,
                                  logic signed [SCORE_W-1:0] score);
            label_result_t e;
            if (pending_labels.size() == 0)
            begin
                mismatches++;
                $error("result beat with none expected: chosen_label %0d best_score %0d",
                       label, score);
                return;
            end
            e = pending_labels.pop_front();
            if (label !== e.label)
            begin
                mismatches++;
                $error("chosen_label: expected %0d, actual %0d", e.label, label);
            end
            if (changed !== e.changed)
            begin
                mismatches++;
                $error("label_changed: expected %0d, actual %0d", e.changed, changed);
            end
            if (score !== e.score)
            begin
                mismatches++;
                $error("best_score: expected %0d, actual %0d", e.score, score);
            end
        endfunction

    endclass

endpackage

// ===== bench/tb.sv =====
// Top of the neighbor weighted color label bench: clock, reset, beat drivers,
// result monitor and run control. Depends on nwcl_pkg and nwcl_label_check_pkg.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import nwcl_pkg::*;
    import nwcl_label_check_pkg::*;

    localparam int DRAIN_CYCLES = 2 * MEAN_SLOTS + 8;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [WEIGHT_W-1:0]         cfg_data;
    logic                        pixel_valid;
    logic                        pixel_ready;
    logic                        func;
    logic [LABEL_W-1:0]          mean_index;
    logic [COLOR_W-1:0]          red;
    logic [COLOR_W-1:0]          green;
    logic [COLOR_W-1:0]          blue;
    logic [LABEL_W-1:0]          current_label;
    logic [NBR_W-1:0]            neighbour_labels;
    logic                        result_valid;
    logic                        result_ready;
    logic [LABEL_W-1:0]          chosen_label;
    logic                        label_changed;
    logic signed [SCORE_W-1:0]   best_score;

    bit               idle_on = 1'b1;
    label_scoreboard  sb;

    neighbor_weighted_color_label dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pixel_valid      (pixel_valid),
        .pixel_ready      (pixel_ready),
        .func             (func),
        .mean_index       (mean_index),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .current_label    (current_label),
        .neighbour_labels (neighbour_labels),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .chosen_label     (chosen_label),
        .label_changed    (label_changed),
        .best_score       (best_score)
    );

    always #2 clk = ~clk;

    function automatic pixel_beat_t load_beat(int slot, int r, int g, int b);
        pixel_beat_t p;
        p.func = FUNC_LOAD;
        p.mean_index = LABEL_W'(slot);
        p.red = COLOR_W'(r);
        p.green = COLOR_W'(g);
        p.blue = COLOR_W'(b);
        p.current_label = '0;
        p.neighbour_labels = '0;
        return p;
    endfunction

    function automatic pixel_beat_t pixel_beat(int r, int g, int b, int cur,
                                               logic [NBR_W-1:0] nbr);
        pixel_beat_t p;
        p.func = FUNC_LABEL;
        p.mean_index = LABEL_W'($urandom_range(0, 15));
        p.red = COLOR_W'(r);
        p.green = COLOR_W'(g);
        p.blue = COLOR_W'(b);
        p.current_label = LABEL_W'(cur);
        p.neighbour_labels = nbr;
        return p;
    endfunction

    function automatic pixel_beat_t random_beat(int k);
        pixel_beat_t p;
        logic [LABEL_W-1:0] favored;
        int d;
        favored = LABEL_W'($urandom_range(0, k - 1));
        p.func = ($urandom_range(0, 4) == 0) ? FUNC_LOAD : FUNC_LABEL;
        p.mean_index = LABEL_W'($urandom_range(0, 15));
        p.red = COLOR_W'($urandom_range(0, 255));
        p.green = COLOR_W'($urandom_range(0, 255));
        p.blue = COLOR_W'($urandom_range(0, 255));
        p.current_label = ($urandom_range(0, 1) == 0) ? favored
                                                      : LABEL_W'($urandom_range(0, 15));
        for (d = 0; d < NBR_COUNT; d++)
        begin
            case ($urandom_range(0, 3))
                0: p.neighbour_labels[LABEL_W*d +: LABEL_W] = LABEL_W'($urandom_range(0, 15));
                3: p.neighbour_labels[LABEL_W*d +: LABEL_W] = LABEL_W'($urandom_range(0, k - 1));
                default: p.neighbour_labels[LABEL_W*d +: LABEL_W] = favored;
            endcase
        end
        if ($urandom_range(0, 9) == 0)
            p.neighbour_labels = NBR_W'($urandom);
        return p;
    endfunction

    task automatic send_beat(input pixel_beat_t p);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        pixel_valid      <= 1'b1;
        func             <= p.func;
        mean_index       <= p.mean_index;
        red              <= p.red;
        green            <= p.green;
        blue             <= p.blue;
        current_label    <= p.current_label;
        neighbour_labels <= p.neighbour_labels;
        do
            @(posedge clk);
        while (!pixel_ready);
        sb.note_beat(p);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [WEIGHT_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(index, data);
    endtask

    // drop valid, wait out every pending result, then let loads clear the chain
    task automatic drain_chain();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        result_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                result_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_label(chosen_label, label_changed, best_score);
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [MEANS_W-1:0] phase_count [8];
        int                 phase_weight [8];
        int                 p;
        int                 slot;
        phase_count  = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd13, 5'd8, 5'd16, 5'd16};
        phase_weight = '{65535, 0, -1, -1, 4000, -1, 0, -1};
        sb = new;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        pixel_valid      = 1'b0;
        func             = 1'b0;
        mean_index       = '0;
        red              = '0;
        green            = '0;
        blue             = '0;
        current_label    = '0;
        neighbour_labels = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // fill every slot before any pixel reads it
        for (slot = 0; slot < MEAN_SLOTS; slot++)
        begin
            case (slot)
                0:       send_beat(load_beat(slot, 0, 0, 0));
                1:       send_beat(load_beat(slot, 255, 0, 0));
                2:       send_beat(load_beat(slot, 0, 255, 0));
                3, 4:    send_beat(load_beat(slot, 100, 100, 100));
                15:      send_beat(load_beat(slot, 255, 255, 255));
                default: send_beat(load_beat(slot, $urandom_range(0, 255),
                                             $urandom_range(0, 255), $urandom_range(0, 255)));
            endcase
        end
        send_beat(pixel_beat(255, 255, 255, 0, 32'hFFFF_FFFF));
        send_beat(pixel_beat(0, 0, 0, 0, 32'h0000_0000));
        send_beat(pixel_beat(100, 100, 100, 3, 32'hEEEE_EEEE));
        send_beat(pixel_beat(100, 100, 100, 15, 32'h4444_4444));
        send_beat(pixel_beat(200, 17, 90, 12, 32'hC0C0_1234));

        drain_chain();
        write_reg(REG_MEANS_IN_USE, 16'd16);
        write_reg(REG_ADJACENCY_WEIGHT, 16'hFFFF);
        send_beat(pixel_beat(0, 0, 0, 0, 32'h0000_0000));
        send_beat(pixel_beat(255, 255, 255, 15, 32'hFFFF_FFFF));

        drain_chain();
        write_reg(REG_MEANS_IN_USE, 16'd0);
        send_beat(pixel_beat(255, 255, 255, 1, 32'h1111_1111));

        for (p = 0; p < 8; p++)
        begin
            drain_chain();
            write_reg(REG_MEANS_IN_USE, WEIGHT_W'(phase_count[p]));
            write_reg(REG_ADJACENCY_WEIGHT,
                      (phase_weight[p] < 0) ? WEIGHT_W'($urandom_range(0, 65535))
                                            : WEIGHT_W'(phase_weight[p]));
            idle_on = (p != 7);
            repeat (60) send_beat(random_beat(sb.active_means()));
        end

        drain_chain();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
